@@ hw/rtl/gha_pkg.sv @@
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants of the generational handle allocator
// Operation and status codes, field widths and the command word that passes
// from the front part to the back part.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int IDX_BITS = 24;
  localparam int GEN_BITS = 8;
  localparam int CFG_BITS = 11;

  localparam logic [IDX_BITS-1:0] INVALID_INDEX   = 24'hFFFFFF;
  localparam logic [GEN_BITS-1:0] INVALID_GEN     = 8'hFF;
  localparam logic [CFG_BITS-1:0] MAX_SLOTS_RESET = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_EXISTS  = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  // Classified command held in the queue between front and back
  typedef struct packed {
    func_t               func;
    logic [IDX_BITS-1:0] index;
    logic [GEN_BITS-1:0] generation;
    logic                in_range;
  } cmd_t;

endpackage

@@ hw/rtl/gha_if.sv @@
// ----------------------------------------------------------------------------
// gha_if: request and response channels of the handle allocator
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface gha_req_if import gha_pkg::*;;
  logic                valid;
  logic                ready;
  func_t               func;
  logic [IDX_BITS-1:0] index;
  logic [GEN_BITS-1:0] generation;

  modport source (output valid, output func, output index, output generation, input ready);
  modport sink   (input valid, input func, input index, input generation, output ready);
endinterface

interface gha_rsp_if import gha_pkg::*;;
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] handle_index;
  logic [GEN_BITS-1:0] handle_generation;
  status_t             status;
  logic                exists;

  modport source (output valid, output handle_index, output handle_generation,
                  output status, output exists, input ready);
  modport sink   (input valid, input handle_index, input handle_generation,
                  input status, input exists, output ready);
endinterface

@@ hw/rtl/generational_handle_allocator.sv @@
// ----------------------------------------------------------------------------
// generational_handle_allocator: generational handle pool
// Creates, destroys and checks handles of a 24-bit slot index and an 8-bit
// generation, reusing freed slots oldest first.
// ----------------------------------------------------------------------------
// After reset the block clears its generation store, one slot a cycle, and
// takes no request until done; cfg writes are taken meanwhile. Each request
// then passes the execution part in steps (queue pop, free FIFO head read,
// generation read, update and response), set by the two registered RAM
// reads in series; a two-entry request queue and the response register let
// requests arrive and responses wait independently. max_slots limits the
// slots in use; the user writes it only while the block is idle, unenforced.
module generational_handle_allocator import gha_pkg::*; #(
  parameter int SLOT_CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  gha_req_if.sink             req,
  gha_rsp_if.source           rsp,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int CW = $clog2(SLOT_CAPACITY + 1);

  logic [CFG_BITS-1:0] max_slots;
  logic [CW-1:0]       lim;
  logic                cmd_valid;
  cmd_t                cmd;
  logic                cmd_pop;
  logic                clearing;

  // Hold the slot limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots <= MAX_SLOTS_RESET;
    end else if (cfg_we) begin
      max_slots <= cfg_wdata;
    end
  end

  // Clamp the limit to the built capacity
  assign lim = (32'(max_slots) >= 32'(SLOT_CAPACITY)) ? CW'(SLOT_CAPACITY)
                                                      : CW'(max_slots);

  gha_front #(.SLOT_CAPACITY(SLOT_CAPACITY)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .lim       (lim),
    .clearing  (clearing),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  gha_back #(.SLOT_CAPACITY(SLOT_CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .cmd_valid (cmd_valid),
    .cmd_in    (cmd),
    .cmd_pop   (cmd_pop),
    .clearing  (clearing),
    .rsp       (rsp)
  );

  // No request enters during the clearing pass
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.ready)
    else $error("request accepted during clearing pass");

  // A failed create carries the all-ones handle
  a_fail_handle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_NO_SLOT) |->
      (rsp.handle_index == INVALID_INDEX && rsp.handle_generation == INVALID_GEN))
    else $error("failed create without invalid handle");

  // A positive exists check carries no handle and no error
  a_exists_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.exists) |->
      (rsp.status == ST_DONE && rsp.handle_index == '0 && rsp.handle_generation == '0))
    else $error("exists answer mixed with other fields");

  // The queue is only popped when it holds a command
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");

endmodule

@@ hw/rtl/gha_ram.sv @@
// ----------------------------------------------------------------------------
// gha_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gha_front.sv @@
// ----------------------------------------------------------------------------
// gha_front: request intake and classification
// Accepts request words, checks the index against the slot limit and queues
// the classified command in a two-entry queue for the back part.
// ----------------------------------------------------------------------------
module gha_front import gha_pkg::*; #(
  parameter int SLOT_CAPACITY = 1024
) (
  input  logic  clk,
  input  logic  rst,
  gha_req_if.sink req,
  input  logic [$clog2(SLOT_CAPACITY+1)-1:0] lim,
  input  logic  clearing,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_pop
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       in_cmd;

  assign req.ready = !clearing && (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  // Classify the incoming word
  always_comb begin
    in_cmd.func       = req.func;
    in_cmd.index      = req.index;
    in_cmd.generation = req.generation;
    in_cmd.in_range   = (req.index < IDX_BITS'(lim));
  end

  // Store queue entries
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, cmd_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/gha_back.sv @@
// ----------------------------------------------------------------------------
// gha_back: command execution
// Holds the generation store, the free index FIFO and the counters, runs
// the reset clearing pass and carries out one command at a time into the
// response register.
// ----------------------------------------------------------------------------
module gha_back import gha_pkg::*; #(
  parameter int SLOT_CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic [$clog2(SLOT_CAPACITY+1)-1:0] lim,
  input  logic cmd_valid,
  input  cmd_t cmd_in,
  output logic cmd_pop,
  output logic clearing,
  gha_rsp_if.source rsp
);

  localparam int IW = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int CW = $clog2(SLOT_CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_CAPACITY - 1);
  localparam logic [SW-1:0] CAP_SUM   = SW'(SLOT_CAPACITY);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_LOOKUP = 5'b01000,
    S_EXEC   = 5'b10000
  } state_t;

  state_t        state, state_next;
  cmd_t          cmd, cmd_next;
  logic [IW-1:0] slot, slot_next;
  logic [IW-1:0] head, head_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [CW-1:0] touched, touched_next;
  logic [IW-1:0] clr_addr, clr_addr_next;

  logic                rsp_valid, rsp_valid_next;
  logic [IDX_BITS-1:0] rsp_index, rsp_index_next;
  logic [GEN_BITS-1:0] rsp_gen, rsp_gen_next;
  status_t             rsp_status, rsp_status_next;
  logic                rsp_exists, rsp_exists_next;

  logic                gen_we;
  logic [IW-1:0]       gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [GEN_BITS-1:0] gen_rdata;
  logic                fifo_we;
  logic [IW-1:0]       fifo_waddr;
  logic [IW-1:0]       fifo_rdata;

  logic          out_free;
  logic [CW-1:0] base_count;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] tail_pos;

  gha_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOT_CAPACITY)) u_gen_ram (
    .clk   (clk),
    .we    (gen_we),
    .waddr (gen_waddr),
    .wdata (gen_wdata),
    .raddr (slot),
    .rdata (gen_rdata)
  );

  gha_ram #(.WIDTH(IW), .DEPTH(SLOT_CAPACITY)) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (slot),
    .raddr (head),
    .rdata (fifo_rdata)
  );

  assign clearing          = (state == S_CLEAR);
  assign out_free          = !rsp_valid || rsp.ready;
  assign rsp.valid         = rsp_valid;
  assign rsp.handle_index  = rsp_index;
  assign rsp.handle_generation = rsp_gen;
  assign rsp.status        = rsp_status;
  assign rsp.exists        = rsp_exists;

  // Tail position for a destroy: empty the FIFO first when it is full
  assign base_count = (free_count >= lim) ? '0 : free_count;
  assign tail_sum   = SW'(head) + SW'(base_count);
  assign tail_pos   = (tail_sum >= CAP_SUM) ? (tail_sum - CAP_SUM) : tail_sum;
  assign fifo_waddr = tail_pos[IW-1:0];

  // Clear the generation store after reset, then sequence one command: pop, read FIFO head, read generation, execute
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    slot_next       = slot;
    head_next       = head;
    free_count_next = free_count;
    touched_next    = touched;
    clr_addr_next   = clr_addr;
    rsp_valid_next  = rsp_valid && !rsp.ready;
    rsp_index_next  = rsp_index;
    rsp_gen_next    = rsp_gen;
    rsp_status_next = rsp_status;
    rsp_exists_next = rsp_exists;
    cmd_pop         = 1'b0;
    gen_we          = 1'b0;
    gen_waddr       = slot;
    gen_wdata       = '0;
    fifo_we         = 1'b0;

    unique case (state)
      S_CLEAR: begin
        gen_we    = 1'b1;
        gen_waddr = clr_addr;
        if (clr_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cmd_next   = cmd_in;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (cmd.func == FUNC_CREATE) begin
          slot_next = (free_count != '0) ? fifo_rdata : touched[IW-1:0];
        end else begin
          slot_next = cmd.index[IW-1:0];
        end
        state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          rsp_valid_next  = 1'b1;
          rsp_index_next  = '0;
          rsp_gen_next    = '0;
          rsp_status_next = ST_DONE;
          rsp_exists_next = 1'b0;
          state_next      = S_IDLE;
          unique case (cmd.func)
            FUNC_CREATE: begin
              if (free_count != '0) begin
                head_next       = (head == LAST_SLOT) ? '0 : head + 1'b1;
                free_count_next = free_count - 1'b1;
                rsp_index_next  = IDX_BITS'(slot);
                rsp_gen_next    = gen_rdata;
              end else if (touched < lim) begin
                gen_we         = 1'b1;
                touched_next   = touched + 1'b1;
                rsp_index_next = IDX_BITS'(slot);
              end else begin
                rsp_index_next  = INVALID_INDEX;
                rsp_gen_next    = INVALID_GEN;
                rsp_status_next = ST_NO_SLOT;
              end
            end
            FUNC_DESTROY: begin
              if (!cmd.in_range) begin
                rsp_status_next = ST_IGNORED;
              end else begin
                gen_we          = 1'b1;
                gen_wdata       = gen_rdata + 1'b1;
                fifo_we         = 1'b1;
                free_count_next = base_count + 1'b1;
              end
            end
            FUNC_EXISTS: begin
              rsp_exists_next = cmd.in_range && (gen_rdata == cmd.generation);
            end
            FUNC_NONE: begin
              rsp_exists_next = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      head       <= '0;
      free_count <= '0;
      touched    <= '0;
      clr_addr   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      free_count <= free_count_next;
      touched    <= touched_next;
      clr_addr   <= clr_addr_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    slot       <= slot_next;
    rsp_index  <= rsp_index_next;
    rsp_gen    <= rsp_gen_next;
    rsp_status <= rsp_status_next;
    rsp_exists <= rsp_exists_next;
  end

endmodule
